// ===== design/imfp_pkg.sv =====
// Package for the ITCH message filter and packer: request types, the table of
// known message types with their lengths, status codes and controller types.
// No dependencies.
package imfp_pkg;

  localparam int COUNT_W = 7;
  localparam logic [COUNT_W-1:0] COUNT_MAX = 7'd127;
  localparam int LEN_W = 6;
  localparam int BEAT_W = 4;
  localparam int KNOWN_TYPES = 10;

  localparam logic [1:0] STATUS_FORWARD = 2'd0;
  localparam logic [1:0] STATUS_UNKNOWN = 2'd1;
  localparam logic [1:0] STATUS_LENGTH  = 2'd2;

  // Message type codes in ASCII: S R A F E C X D U P.
  localparam logic [7:0] TYPE_CODE [KNOWN_TYPES] = '{
    8'h53, 8'h52, 8'h41, 8'h46, 8'h45, 8'h43, 8'h58, 8'h44, 8'h55, 8'h50
  };
  localparam logic [LEN_W-1:0] TYPE_LEN [KNOWN_TYPES] = '{
    6'd12, 6'd39, 6'd36, 6'd40, 6'd31, 6'd36, 6'd23, 6'd19, 6'd35, 6'd44
  };

  typedef struct packed {
    logic [7:0] payload_byte;
    logic       last_byte;
  } byte_req_t;

  typedef struct packed {
    logic [31:0] data_word;
    logic        start_of_packet;
    logic        end_of_packet;
    logic [1:0]  empty_bytes;
    logic [1:0]  status;
    logic        last_of_run;
  } beat_req_t;

  typedef struct packed {
    logic             hit;
    logic [LEN_W-1:0] len;
  } lookup_t;

  typedef enum logic [1:0] {
    ST_COLLECT,
    ST_DECIDE,
    ST_READ,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic store;
    logic clear_count;
    logic start_msg;
    logic rd_en;
    logic beat_inc;
    logic load_drop;
    logic load_beat;
  } dp_cmd_t;

  typedef struct packed {
    logic known;
    logic length_ok;
    logic last_beat;
    logic out_free;
  } dp_status_t;

  function automatic lookup_t lookup_type(input logic [7:0] code);
    lookup_t r;
    r = '{hit: 1'b0, len: '0};
    for (int k = 0; k < KNOWN_TYPES; k++) begin
      if (!r.hit && code == TYPE_CODE[k]) begin
        r.hit = 1'b1;
        r.len = TYPE_LEN[k];
      end
    end
    return r;
  endfunction

endpackage

// ===== design/imfp_ctrl.sv =====
// Controller of the ITCH message filter and packer: sequences byte collection,
// the type and length decision, and the word reads for each beat.
// Depends on imfp_pkg.
module imfp_ctrl import imfp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       byte_valid,
  input  logic       last_byte,
  input  dp_status_t status,
  output logic       byte_stall,
  output dp_cmd_t    cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_COLLECT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    byte_stall = 1'b1;
    unique case (state)
      ST_COLLECT: begin
        byte_stall = 1'b0;
        cmd.store = byte_valid;
        if (byte_valid && last_byte) begin
          state_next = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (status.known && status.length_ok) begin
          cmd.clear_count = 1'b1;
          cmd.start_msg = 1'b1;
          state_next = ST_READ;
        end else if (status.out_free) begin
          cmd.clear_count = 1'b1;
          cmd.load_drop = 1'b1;
          state_next = ST_COLLECT;
        end
      end
      ST_READ: begin
        cmd.rd_en = 1'b1;
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (status.out_free) begin
          cmd.load_beat = 1'b1;
          if (status.last_beat) begin
            state_next = ST_COLLECT;
          end else begin
            cmd.beat_inc = 1'b1;
            state_next = ST_READ;
          end
        end
      end
      default: begin
        state_next = ST_COLLECT;
      end
    endcase
  end

endmodule

// ===== design/imfp_datapath.sv =====
// Datapath of the ITCH message filter and packer: byte store, byte counter,
// type lookup, beat counter and the result register.
// Depends on imfp_pkg.
module imfp_datapath import imfp_pkg::*; #(
  parameter int STORE_BYTES = 64
) (
  input  logic       clk,
  input  logic       rst,
  input  byte_req_t  byte_req,
  input  dp_cmd_t    cmd,
  output dp_status_t status,
  output logic       beat_valid,
  input  logic       beat_stall,
  output beat_req_t  beat_req
);

  localparam int WORDS = (STORE_BYTES + 3) / 4;
  localparam int ADDR_W = $clog2(WORDS);
  localparam int IDX_W = COUNT_W - 2;
  localparam int WIDE_W = (ADDR_W > IDX_W) ? ADDR_W : IDX_W;

  logic [31:0] mem [WORDS];
  logic [31:0] rd_word;
  logic [COUNT_W-1:0] count;
  logic [7:0] msg_type;
  logic [BEAT_W-1:0] beat;
  logic [BEAT_W-1:0] last_idx;
  logic [1:0] pad;

  lookup_t lk;
  logic store_en;
  logic [WIDE_W-1:0] widx;
  logic [ADDR_W-1:0] waddr;
  logic [ADDR_W-1:0] raddr;
  logic [LEN_W-1:0] len_m1;
  logic [31:0] masked;
  beat_req_t drop_req;
  beat_req_t fwd_req;

  assign lk = lookup_type(msg_type);
  assign store_en = 32'(count) < 32'(STORE_BYTES);
  assign widx = WIDE_W'(count[COUNT_W-1:2]);
  assign waddr = widx[ADDR_W-1:0];
  assign raddr = ADDR_W'(beat);
  assign len_m1 = lk.len - LEN_W'(1);

  assign status.known = lk.hit;
  assign status.length_ok = count == {1'b0, lk.len};
  assign status.last_beat = beat == last_idx;
  assign status.out_free = !beat_valid || !beat_stall;

  always_ff @(posedge clk) begin
    if (cmd.store && store_en) begin
      mem[waddr][{count[1:0], 3'b000} +: 8] <= byte_req.payload_byte;
    end
    if (cmd.rd_en) begin
      rd_word <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.clear_count) begin
      count <= '0;
    end else if (cmd.store && count != COUNT_MAX) begin
      count <= count + COUNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.store && count == '0) begin
      msg_type <= byte_req.payload_byte;
    end
    if (cmd.start_msg) begin
      beat <= '0;
      last_idx <= len_m1[LEN_W-1:2];
      pad <= 2'd0 - lk.len[1:0];
    end else if (cmd.beat_inc) begin
      beat <= beat + BEAT_W'(1);
    end
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      if (!status.last_beat || (3'(i) + {1'b0, pad}) < 3'd4) begin
        masked[8*i +: 8] = rd_word[8*i +: 8];
      end else begin
        masked[8*i +: 8] = 8'd0;
      end
    end
  end

  always_comb begin
    drop_req = '0;
    drop_req.status = lk.hit ? STATUS_LENGTH : STATUS_UNKNOWN;
    drop_req.last_of_run = 1'b1;

    fwd_req.data_word = masked;
    fwd_req.start_of_packet = beat == '0;
    fwd_req.end_of_packet = status.last_beat;
    fwd_req.empty_bytes = status.last_beat ? pad : 2'd0;
    fwd_req.status = STATUS_FORWARD;
    fwd_req.last_of_run = status.last_beat;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      beat_valid <= 1'b0;
    end else if (cmd.load_drop || cmd.load_beat) begin
      beat_valid <= 1'b1;
    end else if (!beat_stall) begin
      beat_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_drop) begin
      beat_req <= drop_req;
    end else if (cmd.load_beat) begin
      beat_req <= fwd_req;
    end
  end

endmodule

// ===== design/itch_message_filter_packer_unit.sv =====
// Bytes are taken one per cycle while the unit collects; after the last byte the
// unit stalls bytes and decides. A dropped datagram loads its drop result once
// the result register is free. A forwarded message does a store word read and
// then a result load for each beat, the load waiting until the register is free.
// Reset clears the controller, the byte count and the result valid; the byte
// store is not cleared and needs no clearing pass.
module itch_message_filter_packer_unit import imfp_pkg::*; #(
  parameter int STORE_BYTES = 64
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      byte_valid,
  output logic      byte_stall,
  input  byte_req_t byte_req,
  output logic      beat_valid,
  input  logic      beat_stall,
  output beat_req_t beat_req
);

  dp_cmd_t    cmd;
  dp_status_t status;

  imfp_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .last_byte  (byte_req.last_byte),
    .status     (status),
    .byte_stall (byte_stall),
    .cmd        (cmd)
  );

  imfp_datapath #(
    .STORE_BYTES (STORE_BYTES)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .byte_req   (byte_req),
    .cmd        (cmd),
    .status     (status),
    .beat_valid (beat_valid),
    .beat_stall (beat_stall),
    .beat_req   (beat_req)
  );

`ifndef SYNTHESIS
  a_stall_after_last: assert property (@(posedge clk) disable iff (rst)
    byte_valid && !byte_stall && byte_req.last_byte |=> byte_stall)
    else $error("byte request accepted right after a last byte");

  a_drop_shape: assert property (@(posedge clk) disable iff (rst)
    beat_valid && beat_req.status != STATUS_FORWARD |->
      beat_req.last_of_run && beat_req.data_word == 32'd0 &&
      !beat_req.start_of_packet && !beat_req.end_of_packet)
    else $error("malformed drop result");

  a_eop_ends_run: assert property (@(posedge clk) disable iff (rst)
    beat_valid && beat_req.status == STATUS_FORWARD |->
      beat_req.end_of_packet == beat_req.last_of_run)
    else $error("end of packet and end of run disagree");
`endif

endmodule

// ===== bench/tb_itch_message_filter_packer_unit.sv =====
// Testbench for itch_message_filter_packer_unit: drives whole datagrams byte by byte,
// predicts the forwarded beats and drop results, and checks every result request.
// Depends on imfp_pkg and the unit itself.
module tb_itch_message_filter_packer_unit;
  import imfp_pkg::*;

  localparam int STORE_BYTES = 64;
  localparam int IDLE_MAX = 18;
  localparam int TOTAL_BYTES = 430;
  localparam int HOLD_AT_BEAT = 20;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_CYCLES = 40;
  localparam int RUN_LIMIT = 2000000;

  class beat_scoreboard;
    logic [7:0] store [STORE_BYTES];
    logic [COUNT_W-1:0] count;
    beat_req_t pending [$];
    int errors;
    int beats_seen;
    int predicted;
    int messages;
    int drops;

    function new();
      count = '0;
      errors = 0;
      beats_seen = 0;
      predicted = 0;
      messages = 0;
      drops = 0;
      foreach (store[i]) store[i] = '0;
    endfunction

    function int message_length(logic [7:0] code);
      int len;
      len = -1;
      for (int k = 0; k < KNOWN_TYPES; k++)
        if (len < 0 && TYPE_CODE[k] == code) len = int'(TYPE_LEN[k]);
      return len;
    endfunction

    function void push_drop(logic [1:0] code);
      beat_req_t d;
      d = '0;
      d.status = code;
      d.last_of_run = 1'b1;
      pending.push_back(d);
      predicted++;
      drops++;
    endfunction

    function void note_byte(byte_req_t r);
      int total;
      int want;
      int nbeats;
      beat_req_t b;
      if (count < STORE_BYTES) store[count] = r.payload_byte;
      if (count != COUNT_MAX) count = count + 1'b1;
      if (!r.last_byte) return;
      total = int'(count);
      count = '0;
      want = message_length(store[0]);
      if (want < 0) begin
        push_drop(STATUS_UNKNOWN);
      end else if (total != want) begin
        push_drop(STATUS_LENGTH);
      end else begin
        nbeats = (want + 3) / 4;
        messages++;
        for (int k = 0; k < nbeats; k++) begin
          b = '0;
          for (int lane = 0; lane < 4; lane++)
            if (k * 4 + lane < want) b.data_word[8 * lane +: 8] = store[k * 4 + lane];
          b.start_of_packet = (k == 0);
          b.end_of_packet = (k == nbeats - 1);
          b.empty_bytes = b.end_of_packet ? 2'((4 - want % 4) % 4) : 2'd0;
          b.status = STATUS_FORWARD;
          b.last_of_run = b.end_of_packet;
          pending.push_back(b);
          predicted++;
        end
      end
    endfunction

    function void check_beat(beat_req_t got);
      beat_req_t want_beat;
      beats_seen++;
      if (pending.size() == 0) begin
        $error("Result %h arrived with no result pending", got);
        errors++;
        return;
      end
      want_beat = pending.pop_front();
      if (got.data_word !== want_beat.data_word) begin
        $error("data_word: expected %h, got %h", want_beat.data_word, got.data_word);
        errors++;
      end
      if (got.start_of_packet !== want_beat.start_of_packet) begin
        $error("start_of_packet: expected %b, got %b", want_beat.start_of_packet,
               got.start_of_packet);
        errors++;
      end
      if (got.end_of_packet !== want_beat.end_of_packet) begin
        $error("end_of_packet: expected %b, got %b", want_beat.end_of_packet,
               got.end_of_packet);
        errors++;
      end
      if (got.empty_bytes !== want_beat.empty_bytes) begin
        $error("empty_bytes: expected %0d, got %0d", want_beat.empty_bytes, got.empty_bytes);
        errors++;
      end
      if (got.status !== want_beat.status) begin
        $error("status: expected %0d, got %0d", want_beat.status, got.status);
        errors++;
      end
      if (got.last_of_run !== want_beat.last_of_run) begin
        $error("last_of_run: expected %b, got %b", want_beat.last_of_run, got.last_of_run);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic byte_valid;
  logic byte_stall;
  byte_req_t byte_req;
  logic beat_valid;
  logic beat_stall;
  beat_req_t beat_req;

  beat_scoreboard sb;
  int send_idle;
  int recv_idle;
  int bytes_sent;
  int datagrams_sent;

  itch_message_filter_packer_unit #(.STORE_BYTES(STORE_BYTES)) uut (
    .clk(clk),
    .rst(rst),
    .byte_valid(byte_valid),
    .byte_stall(byte_stall),
    .byte_req(byte_req),
    .beat_valid(beat_valid),
    .beat_stall(beat_stall),
    .beat_req(beat_req)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #RUN_LIMIT;
    $display("Run timed out with %0d results still pending.", sb.pending.size());
    $display("FAIL");
    $finish;
  end

  task automatic send_byte(input logic [7:0] value, input logic last);
    int gap;
    byte_req_t r;
    r = '{payload_byte: value, last_byte: last};
    gap = $urandom_range(0, send_idle);
    if (gap > 0) begin
      byte_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    byte_valid <= 1'b1;
    byte_req <= r;
    do @(posedge clk); while (byte_stall);
    sb.note_byte(r);
    bytes_sent++;
  endtask

  task automatic send_datagram(input logic [7:0] code, input int len, input int fill);
    logic [7:0] value;
    send_idle = ($urandom_range(0, 3) == 0) ? 0 : IDLE_MAX;
    for (int i = 0; i < len; i++) begin
      value = (i == 0) ? code : (fill < 0) ? 8'($urandom) : 8'(fill);
      send_byte(value, i == len - 1);
    end
    datagrams_sent++;
  endtask

  task automatic send_random_datagram();
    int pick;
    int k;
    int len;
    int delta;
    logic [7:0] code;
    pick = $urandom_range(0, 99);
    k = $urandom_range(0, KNOWN_TYPES - 1);
    code = TYPE_CODE[k];
    len = int'(TYPE_LEN[k]);
    if (pick >= 95) begin
      code = 8'($urandom);
      len = $urandom_range(1, 8);
    end else if (pick >= 88) begin
      if ($urandom_range(0, 1) == 1) code = 8'($urandom);
      len = $urandom_range(STORE_BYTES + 1, 140);
    end else if (pick >= 80) begin
      do code = 8'($urandom); while (sb.message_length(code) >= 0);
      len = $urandom_range(1, 48);
    end else if (pick >= 70) begin
      delta = $urandom_range(1, 5);
      if ($urandom_range(0, 1) == 1) len += delta;
      else len -= delta;
    end
    send_datagram(code, len, -1);
  endtask

  initial begin
    sb = new();
    rst <= 1'b1;
    byte_valid <= 1'b0;
    byte_req <= '0;
    send_idle = 0;
    bytes_sent = 0;
    datagrams_sent = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    send_datagram(8'h00, 1, -1);
    send_datagram(8'hFF, 1, -1);
    send_datagram(TYPE_CODE[0], 1, -1);
    send_datagram(TYPE_CODE[0], int'(TYPE_LEN[0]) - 1, -1);
    send_datagram(TYPE_CODE[0], int'(TYPE_LEN[0]) + 1, -1);
    send_datagram(TYPE_CODE[0], int'(TYPE_LEN[0]), 8'hFF);
    send_datagram(TYPE_CODE[7], int'(TYPE_LEN[7]), 8'h00);
    send_datagram(TYPE_CODE[9], 130, -1);
    send_datagram(TYPE_CODE[3], int'(TYPE_LEN[3]), -1);

    while (bytes_sent < TOTAL_BYTES)
      send_random_datagram();

    byte_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d bytes in %0d datagrams; checked %0d results.",
             bytes_sent, datagrams_sent, sb.beats_seen);
    $display("Predicted %0d forwarded messages and %0d drops; %0d mismatches.",
             sb.messages, sb.drops, sb.errors);
    if (sb.errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

  initial begin
    int gap;
    beat_stall <= 1'b0;
    recv_idle = 0;
    do @(posedge clk); while (rst);
    forever begin
      if (sb.beats_seen % 16 == 0) recv_idle = ($urandom_range(0, 2) == 0) ? 0 : IDLE_MAX;
      gap = (sb.beats_seen == HOLD_AT_BEAT) ? HOLD_CYCLES : $urandom_range(0, recv_idle);
      if (gap > 0) begin
        beat_stall <= 1'b1;
        repeat (gap) @(posedge clk);
        beat_stall <= 1'b0;
      end
      do @(posedge clk); while (!beat_valid);
      sb.check_beat(beat_req);
    end
  end

endmodule
